/* design/vfat_long_name_assembler_defines.svh */
// ----------------------------------------------------------------------------
// VFAT long-name assembler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VFAT_LONG_NAME_ASSEMBLER_DEFINES_SVH
`define VFAT_LONG_NAME_ASSEMBLER_DEFINES_SVH

// same-cycle implication
`define VFAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VFAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/vfat_lna_pkg.sv */
// ----------------------------------------------------------------------------
// VFAT long-name assembler package
// Shared constants, types and helper functions.
// ----------------------------------------------------------------------------
package vfat_lna_pkg;

  localparam int NAME_LIMIT  = 32;
  localparam int MAX_RESULTS = 32;
  localparam int STREAM_MAX  = (NAME_LIMIT < MAX_RESULTS) ? NAME_LIMIT : MAX_RESULTS;
  localparam int IDX_W       = $clog2(NAME_LIMIT);
  localparam int NUM_SLOTS   = 13;
  localparam int POS_W       = 9;   // (31-1)*13+12 fits
  localparam int CHAR_W      = 7;
  localparam int SEQ_W       = 5;
  localparam int ENTRY_W     = 256;

  localparam logic [4:0] SLOT_OFF [NUM_SLOTS] =
    '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30};

  localparam logic [7:0]  SEQ_MASK   = 8'h1F;
  localparam logic [7:0]  FIRST_FLAG = 8'h40;
  localparam logic [15:0] CHAR_LO    = 16'h0020;
  localparam logic [15:0] CHAR_HI    = 16'h007E;
  localparam logic [15:0] SLOT_SKIP  = 16'hFFFF;
  localparam logic [7:0]  DEL_MARK   = 8'hE5;
  localparam logic [7:0]  ATTR_MASK  = 8'h3F;
  localparam logic [7:0]  ATTR_LFN   = 8'h0F;

  typedef enum logic [2:0] {
    KIND_END       = 3'd0,
    KIND_LONG      = 3'd1,
    KIND_DEL_LONG  = 3'd2,
    KIND_DEL_SHORT = 3'd3,
    KIND_SHORT     = 3'd4
  } kind_t;

  typedef struct packed {
    logic              we;
    logic              bad;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
  } lane_res_t;

  // one rotate-right-and-add step of the 8.3 checksum
  function automatic logic [7:0] sum_step(input logic [7:0] s, input logic [7:0] b);
    return {s[0], s[7:1]} + b;
  endfunction

endpackage

/* design/vfat_lna_lane.sv */
// ----------------------------------------------------------------------------
// VFAT long-name slot lane
// Decodes one UCS-2 slot of a long-name part into a store write, a fault or neither.
// ----------------------------------------------------------------------------
module vfat_lna_lane (
  input  logic [15:0]                      slot_val,
  input  logic [vfat_lna_pkg::SEQ_W-1:0]   seq,
  input  logic [3:0]                       lane_idx,
  input  logic                             stop_in,   // an earlier slot held 0x0000
  output logic                             stop_out,
  output vfat_lna_pkg::lane_res_t          res
);

  logic [vfat_lna_pkg::SEQ_W-1:0] seq_m1;
  logic [vfat_lna_pkg::POS_W-1:0] pos;
  logic                           active;
  logic                           skip;
  logic                           bad;

  assign seq_m1   = seq - vfat_lna_pkg::SEQ_W'(1);
  assign pos      = vfat_lna_pkg::POS_W'(seq_m1) * vfat_lna_pkg::POS_W'(13)
                  + vfat_lna_pkg::POS_W'(lane_idx);
  assign active   = !stop_in && (slot_val != 16'h0000);
  assign stop_out = stop_in || (slot_val == 16'h0000);
  assign skip     = (slot_val == vfat_lna_pkg::SLOT_SKIP);
  assign bad      = (slot_val < vfat_lna_pkg::CHAR_LO) || (slot_val > vfat_lna_pkg::CHAR_HI)
                 || (pos >= vfat_lna_pkg::POS_W'(vfat_lna_pkg::NAME_LIMIT));

  assign res.we  = active && !skip && !bad;
  assign res.bad = active && !skip && bad;
  assign res.idx = pos[vfat_lna_pkg::IDX_W-1:0];
  assign res.ch  = slot_val[vfat_lna_pkg::CHAR_W-1:0];

endmodule

/* design/vfat_lna_merge.sv */
// ----------------------------------------------------------------------------
// VFAT long-name lane merge
// Folds the slot lanes into a per-entry write mask, write data and fault flag.
// ----------------------------------------------------------------------------
module vfat_lna_merge (
  input  vfat_lna_pkg::lane_res_t           lanes   [vfat_lna_pkg::NUM_SLOTS],
  output logic [vfat_lna_pkg::NAME_LIMIT-1:0] wr_mask,
  output logic [vfat_lna_pkg::CHAR_W-1:0]     wr_data [vfat_lna_pkg::NAME_LIMIT],
  output logic                                bad_any
);

  // lanes of one part always target distinct positions, so an OR mux is safe
  always_comb begin
    wr_mask = '0;
    bad_any = 1'b0;
    for (int k = 0; k < vfat_lna_pkg::NAME_LIMIT; k++) begin
      wr_data[k] = '0;
    end
    for (int i = 0; i < vfat_lna_pkg::NUM_SLOTS; i++) begin
      bad_any = bad_any | lanes[i].bad;
      for (int k = 0; k < vfat_lna_pkg::NAME_LIMIT; k++) begin
        if (lanes[i].we && (lanes[i].idx == vfat_lna_pkg::IDX_W'(k))) begin
          wr_mask[k] = 1'b1;
          wr_data[k] = wr_data[k] | lanes[i].ch;
        end
      end
    end
  end

endmodule

/* design/vfat_long_name_assembler.sv */
// Flow: an accepted entry passes through S_CHK1 and S_CHK2 (the 8.3 checksum),
// then S_EMIT, which registers the result words; an accepted short entry with an
// n-character name gives n words, one character per cycle while out_tready allows.
// in_tready is low outside S_IDLE, so a new entry is taken only after the last word.
// Reset: synchronous rst_n clears all tracking state and the name valid bits
// at once; no clearing pass, entries are accepted right after reset.
// ----------------------------------------------------------------------------
// VFAT long-name assembler
// Classifies directory entries, gathers long names over 13 slot lanes and
// streams an accepted name one character per output word.
// ----------------------------------------------------------------------------
`include "vfat_long_name_assembler_defines.svh"

module vfat_long_name_assembler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,   // entry_bytes_0_7, entry_bytes_8_15,
                                   // entry_bytes_16_23, entry_bytes_24_31
  input  logic         in_tuser,   // start_of_directory
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // name_char[6:0], char_index[12:7], zero pad
  output logic [5:0]   out_tuser,  // entry_kind[2:0], had_long_name, name_accepted,
                                   // char_valid
  output logic         out_tlast   // last
);

  localparam int NL = vfat_lna_pkg::NAME_LIMIT;
  localparam int IW = vfat_lna_pkg::IDX_W;
  localparam int CW = vfat_lna_pkg::CHAR_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CHK1 = 4'b0010,
    S_CHK2 = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [255:0]                entry_r;
  logic                        sod_r;
  logic [7:0]                  sum_r, sum_nxt;
  logic [IW-1:0]               cnt_r, cnt_nxt;

  logic                        gathering_r, gathering_nxt;
  logic                        name_valid_r, name_valid_nxt;
  logic [4:0]                  exp_r, exp_nxt;
  logic [15:0]                 parts_r, parts_nxt;
  logic [7:0]                  chk_r, chk_nxt;
  logic [NL-1:0]               vld_r, vld_nxt;
  logic [CW-1:0]               store_r [NL];

  logic                        out_valid_r, out_valid_nxt;
  logic [15:0]                 out_tdata_r, out_tdata_nxt;
  logic [5:0]                  out_tuser_r, out_tuser_nxt;
  logic                        out_tlast_r, out_tlast_nxt;

  logic                        in_acc;
  logic                        out_load;
  logic                        commit;

  // entry decode
  logic [7:0]                  b0, attr, b13;
  logic [4:0]                  seq;
  logic                        is_lfn, is_del;
  vfat_lna_pkg::kind_t         kind;

  // lanes
  logic [vfat_lna_pkg::NUM_SLOTS:0] stop;
  vfat_lna_pkg::lane_res_t     lane_res [vfat_lna_pkg::NUM_SLOTS];
  logic [NL-1:0]               wr_mask;
  logic [CW-1:0]               wr_data [NL];
  logic                        bad_any;

  // short-entry test and streaming
  logic [7:0]                  need;
  logic                        passes;
  logic                        streaming;
  logic [NL-1:0]               vld_up;
  logic                        emit_last;
  logic [15:0]                 parts_bit;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = !out_valid_r || out_tready;
  assign commit    = (state_r == S_EMIT) && out_load;

  assign b0     = entry_r[7:0];
  assign attr   = entry_r[95:88];
  assign b13    = entry_r[111:104];
  assign seq    = 5'(b0 & vfat_lna_pkg::SEQ_MASK);
  assign is_lfn = ((attr & vfat_lna_pkg::ATTR_MASK) == vfat_lna_pkg::ATTR_LFN);
  assign is_del = (b0 == vfat_lna_pkg::DEL_MARK);

  always_comb begin
    if (b0 == 8'h00) begin
      kind = vfat_lna_pkg::KIND_END;
    end else if (is_lfn && is_del) begin
      kind = vfat_lna_pkg::KIND_DEL_LONG;
    end else if (is_lfn) begin
      kind = vfat_lna_pkg::KIND_LONG;
    end else if (is_del) begin
      kind = vfat_lna_pkg::KIND_DEL_SHORT;
    end else begin
      kind = vfat_lna_pkg::KIND_SHORT;
    end
  end

  assign stop[0] = 1'b0;
  for (genvar i = 0; i < vfat_lna_pkg::NUM_SLOTS; i++) begin : g_lane
    vfat_lna_lane u_lane (
      .slot_val (entry_r[8*int'(vfat_lna_pkg::SLOT_OFF[i]) +: 16]),
      .seq      (seq),
      .lane_idx (4'(i)),
      .stop_in  (stop[i]),
      .stop_out (stop[i+1]),
      .res      (lane_res[i])
    );
  end

  vfat_lna_merge u_merge (
    .lanes   (lane_res),
    .wr_mask (wr_mask),
    .wr_data (wr_data),
    .bad_any (bad_any)
  );

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      need[k] = (5'(k) < exp_r);
    end
  end

  assign passes = gathering_r && name_valid_r && (exp_r != 5'd0) && (exp_r <= 5'd8)
               && ((parts_r[7:0] & need) == need) && (chk_r == sum_r);
  assign streaming = passes && vld_r[0];
  // stored characters are never zero, so a valid bit marks a nonzero entry
  assign vld_up    = {1'b0, vld_r[NL-1:1]};
  assign emit_last = (kind != vfat_lna_pkg::KIND_SHORT) || !streaming
                  || (cnt_r == IW'(vfat_lna_pkg::STREAM_MAX - 1)) || !vld_up[cnt_r];
  assign parts_bit = (seq <= 5'd16) ? (16'd1 << (seq - 5'd1)) : 16'd0;

  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    gathering_nxt  = gathering_r;
    name_valid_nxt = name_valid_r;
    exp_nxt        = exp_r;
    parts_nxt      = parts_r;
    chk_nxt        = chk_r;
    vld_nxt        = vld_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CHK1;
          cnt_nxt   = '0;
        end
      end
      S_CHK1: begin
        sum_nxt = 8'h00;
        for (int i = 0; i < 6; i++) begin
          sum_nxt = vfat_lna_pkg::sum_step(sum_nxt, entry_r[8*i +: 8]);
        end
        if (sod_r) begin
          gathering_nxt  = 1'b0;
          name_valid_nxt = 1'b0;
          exp_nxt        = '0;
          parts_nxt      = '0;
          chk_nxt        = '0;
          vld_nxt        = '0;
        end
        state_nxt = S_CHK2;
      end
      S_CHK2: begin
        for (int i = 6; i < 11; i++) begin
          sum_nxt = vfat_lna_pkg::sum_step(sum_nxt, entry_r[8*i +: 8]);
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          out_tlast_nxt = emit_last;
          if (kind == vfat_lna_pkg::KIND_SHORT) begin
            out_tuser_nxt = {streaming, passes, gathering_r, kind};
            out_tdata_nxt = streaming ? {3'b000, 6'(cnt_r), store_r[cnt_r]} : 16'h0000;
          end else begin
            out_tuser_nxt = {3'b000, kind};
            out_tdata_nxt = 16'h0000;
          end
          cnt_nxt = cnt_r + IW'(1);
          if (emit_last) begin
            state_nxt = S_IDLE;
            if ((kind == vfat_lna_pkg::KIND_LONG) && (seq != 5'd0)) begin
              if ((b0 & vfat_lna_pkg::FIRST_FLAG) != 8'h00) begin
                gathering_nxt  = 1'b1;
                name_valid_nxt = 1'b1;
                exp_nxt        = seq;
                chk_nxt        = b13;
                parts_nxt      = '0;
                vld_nxt        = '0;
              end else if (!gathering_r) begin
                gathering_nxt  = 1'b1;
                name_valid_nxt = 1'b0;
                exp_nxt        = seq;
                chk_nxt        = b13;
              end
              if ((seq > exp_nxt) || (b13 != chk_nxt) || bad_any) begin
                name_valid_nxt = 1'b0;
              end
              parts_nxt = parts_nxt | parts_bit;
              vld_nxt   = vld_nxt | wr_mask;
            end else begin
              gathering_nxt  = 1'b0;
              name_valid_nxt = 1'b0;
              exp_nxt        = '0;
              parts_nxt      = '0;
              chk_nxt        = '0;
              vld_nxt        = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      gathering_r  <= 1'b0;
      name_valid_r <= 1'b0;
      exp_r        <= '0;
      parts_r      <= '0;
      chk_r        <= '0;
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      gathering_r  <= gathering_nxt;
      name_valid_r <= name_valid_nxt;
      exp_r        <= exp_nxt;
      parts_r      <= parts_nxt;
      chk_r        <= chk_nxt;
      vld_r        <= vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      entry_r <= in_tdata;
      sod_r   <= in_tuser;
    end
    sum_r       <= sum_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  // name store: written by the merged lanes of a committed long-name part
  always_ff @(posedge clk) begin
    for (int k = 0; k < NL; k++) begin
      if (commit && (kind == vfat_lna_pkg::KIND_LONG) && (seq != 5'd0) && wr_mask[k]) begin
        store_r[k] <= wr_data[k];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `VFAT_ASSERT_NEXT(a_accept_starts_chk, in_acc, state_r == S_CHK1,
                    "accept did not start checksum")
  `VFAT_ASSERT_NEXT(a_last_returns_idle, commit && emit_last, state_r == S_IDLE,
                    "no idle after last word")
  `VFAT_ASSERT_NOW(a_char_printable, out_valid_r && out_tuser_r[5],
                   (out_tdata_r[6:0] >= 7'h20) && (out_tdata_r[6:0] <= 7'h7E),
                   "streamed char not printable")
  `VFAT_ASSERT_NOW(a_cnt_bound, state_r == S_EMIT,
                   cnt_r <= IW'(vfat_lna_pkg::STREAM_MAX - 1), "character count overran")

endmodule
